/* rtl/core/kps_pkg.sv */
// ----------------------------------------------------------------------------
// kps_pkg
// shared types, codes and lookup functions of the keypad scanner
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int ROW_W    = 4;
  localparam int COL_W    = 3;
  localparam int KEY_W    = 4;
  localparam int CNT_W    = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_COL0 = 2'd1;
  localparam logic [1:0] PHASE_COL1 = 2'd2;
  localparam logic [1:0] PHASE_COL2 = 2'd3;

  localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd10;

  // scanner state carried between ticks
  typedef struct packed {
    logic [1:0]       phase;
    logic [1:0]       row;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
    logic             pressed;
  } kps_state_t;

  // result of one tick
  typedef struct packed {
    logic             key_event;
    logic             key_pressed;
    logic [KEY_W-1:0] key_code;
    logic [COL_W-1:0] column_drive;
  } kps_result_t;

  // phone layout: row 3 gives star, 0, hash
  function automatic logic [KEY_W-1:0] key_lookup(input logic [1:0] row,
                                                  input logic [1:0] phase);
    logic [KEY_W-1:0] code;
    code = '0;
    case ({row, phase})
      {2'd0, PHASE_COL0}: code = 4'd1;
      {2'd0, PHASE_COL1}: code = 4'd2;
      {2'd0, PHASE_COL2}: code = 4'd3;
      {2'd1, PHASE_COL0}: code = 4'd4;
      {2'd1, PHASE_COL1}: code = 4'd5;
      {2'd1, PHASE_COL2}: code = 4'd6;
      {2'd2, PHASE_COL0}: code = 4'd7;
      {2'd2, PHASE_COL1}: code = 4'd8;
      {2'd2, PHASE_COL2}: code = 4'd9;
      {2'd3, PHASE_COL0}: code = KEY_STAR;
      {2'd3, PHASE_COL1}: code = 4'd0;
      {2'd3, PHASE_COL2}: code = KEY_HASH;
      default:            code = '0;
    endcase
    return code;
  endfunction

  // idle drives all columns low, a scan drives only its column low
  function automatic logic [COL_W-1:0] drive_for_phase(input logic [1:0] phase);
    logic [COL_W-1:0] drive;
    drive = '0;
    case (phase)
      PHASE_COL0: drive = 3'b110;
      PHASE_COL1: drive = 3'b101;
      PHASE_COL2: drive = 3'b011;
      default:    drive = 3'b000;
    endcase
    return drive;
  endfunction

endpackage

/* rtl/core/kps_step.sv */
// ----------------------------------------------------------------------------
// kps_step
// next-state and result logic of the keypad scanner for one tick
// ----------------------------------------------------------------------------
module kps_step
  import kps_pkg::*;
(
  input  kps_state_t       cur,
  input  logic [ROW_W-1:0] row_levels,
  input  logic             clear_pressed,
  input  logic [CNT_W-1:0] debounce_count,
  input  logic             scan_enable,
  output kps_state_t       nxt,
  output kps_result_t      res
);

  logic [1:0]       first_low;
  logic             row_low;
  logic [CNT_W:0]   count_inc;
  logic [CNT_W:0]   need;
  logic             accept_key;

  always_comb begin
    if (!row_levels[0]) begin
      first_low = 2'd0;
    end else if (!row_levels[1]) begin
      first_low = 2'd1;
    end else if (!row_levels[2]) begin
      first_low = 2'd2;
    end else begin
      first_low = 2'd3;
    end
  end

  assign row_low    = ~row_levels[cur.row];
  assign count_inc  = {1'b0, cur.count} + {{CNT_W{1'b0}}, 1'b1};
  assign need       = (debounce_count == '0) ? {{CNT_W{1'b0}}, 1'b1}
                                             : {1'b0, debounce_count};
  assign accept_key = (cur.phase != PHASE_IDLE) && row_low && (count_inc >= need);

  always_comb begin
    nxt = cur;
    if (clear_pressed) begin
      nxt.pressed = 1'b0;
    end
    if (cur.phase == PHASE_IDLE) begin
      if (scan_enable && (row_levels != {ROW_W{1'b1}})) begin
        nxt.row   = first_low;
        nxt.count = '0;
        nxt.phase = PHASE_COL0;
      end
    end else if (row_low) begin
      if (accept_key) begin
        nxt.key     = key_lookup(cur.row, cur.phase);
        nxt.pressed = 1'b1;
        nxt.count   = '0;
        nxt.phase   = PHASE_IDLE;
      end else begin
        nxt.count = count_inc[CNT_W-1:0];
      end
    end else begin
      nxt.count = '0;
      if (cur.phase == PHASE_COL2) begin
        nxt.phase = PHASE_IDLE;
      end else begin
        nxt.phase = cur.phase + 2'd1;
      end
    end
  end

  always_comb begin
    res.column_drive = drive_for_phase(nxt.phase);
    res.key_code     = nxt.key;
    res.key_pressed  = nxt.pressed;
    res.key_event    = accept_key;
  end

endmodule

/* rtl/core/matrix_keypad_scan_debounce.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// 4x3 keypad scanner with per-column debounce and sticky pressed flag
// ----------------------------------------------------------------------------
// each input transaction is one tick: tdata[3:0] row levels (active low),
// tdata[4] clears the pressed flag. every tick yields exactly one output
// transaction with the column drive, latched key code, pressed flag and a
// key event pulse.
// the scan state updates in the cycle the tick is taken, and its result loads
// into the output register at the same edge; while the receiver stalls, it goes
// to the skid register. one tick per clock is sustained while the receiver takes every result.
// a skid register behind the output register takes one more result while
// the receiver stalls; in_tready drops only when the skid register is full.
// config writes (debounce_count at index 0, scan_enable at index 1) land on
// the cycle cfg_wr_en is high and are meant to happen while the block idles.
// reset (synchronous, rst_n low) returns to idle with all columns driven
// low, clears key code and pressed flag, empties the output side, and loads
// debounce_count 10 and scan_enable 1.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce
  import kps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row_levels[3:0], clear_pressed[4]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // column_drive[2:0], key_code[6:3],
                                             // key_pressed[7], key_event[8]
  input  logic                   cfg_wr_en,
  input  logic                   cfg_addr,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_ENABLE   = 1'b1;

  logic [CNT_W-1:0] debounce_r;
  logic             enable_r;
  kps_state_t       state_r;
  kps_state_t       state_nxt;
  kps_result_t      step_res;
  kps_result_t      out_r;
  kps_result_t      out_nxt;
  kps_result_t      skid_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  logic             in_fire;
  logic             out_fire;

  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;

  kps_step u_step (
    .cur            (state_r),
    .row_levels     (in_tdata[ROW_W-1:0]),
    .clear_pressed  (in_tdata[ROW_W]),
    .debounce_count (debounce_r),
    .scan_enable    (enable_r),
    .nxt            (state_nxt),
    .res            (step_res)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      enable_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register and skid register
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = step_res;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_fire && out_valid_r && !out_fire) begin
      skid_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-COL_W-KEY_W-2){1'b0}}, out_r.key_event,
                       out_r.key_pressed, out_r.key_code, out_r.column_drive};

  // idle always holds a cleared debounce counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PHASE_IDLE) |-> (state_r.count == '0))
    else $error("debounce counter not cleared while idle");

  // skid register only fills behind a valid output register
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds data ahead of output register");

  // an accepted key returns the scanner to idle and sets the flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_res.key_event) |=>
      (state_r.phase == PHASE_IDLE) && state_r.pressed)
    else $error("key acceptance did not return to idle");

  // an event in a result always carries the pressed flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.key_event) |-> out_r.key_pressed)
    else $error("key event without pressed flag");

endmodule

/* test/matrix_keypad_scan_debounce_test.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_test
// self-checking bench for the 4x3 keypad scanner: row ticks go in through the
// input stream, a local model of the scan and debounce predicts every output
// transaction, and the monitor checks each one field by field in order
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_test;
  import kps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REG_DEBOUNCE    = 1'b0;
  localparam logic REG_SCAN_ENABLE = 1'b1;
  localparam int   STALL_LIMIT     = 2000;
  localparam int   RX_HOLD_CYCLES  = 64;
  localparam int   MAX_REPORTED    = 20;
  localparam int   DRAIN_CYCLES    = 8;

  typedef struct packed {
    logic             clear;
    logic [ROW_W-1:0] rows;
  } tick_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // row_levels[3:0], clear_pressed[4]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // column_drive[2:0], key_code[6:3],
                                           // key_pressed[7], key_event[8]
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_addr = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;

  tick_t       pending_ticks[$];
  kps_result_t predicted_outputs[$];

  kps_state_t       keypad_state = '0;
  logic [CNT_W-1:0] debounce_setting = DEBOUNCE_RESET;
  logic             scan_enable_setting = 1'b1;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_requested = 0;
  int holds_started = 0;
  int rx_hold_left = 0;
  int stall_cycles = 0;
  int mismatches = 0;
  int checked_results = 0;

  matrix_keypad_scan_debounce dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // one tick of the scanner: updates the model state, returns the output
  function automatic kps_result_t predict_tick(tick_t t);
    kps_result_t      res;
    logic [1:0]       col;
    logic [CNT_W:0]   next_count;
    logic [CNT_W-1:0] need;
    res.key_event = 1'b0;
    if (t.clear) keypad_state.pressed = 1'b0;
    if (keypad_state.phase == PHASE_IDLE) begin
      if (scan_enable_setting && t.rows != 4'hf) begin
        casez (t.rows)
          4'b???0: keypad_state.row = 2'd0;
          4'b??01: keypad_state.row = 2'd1;
          4'b?011: keypad_state.row = 2'd2;
          default: keypad_state.row = 2'd3;
        endcase
        keypad_state.count = '0;
        keypad_state.phase = PHASE_COL0;
      end
    end else if (!t.rows[keypad_state.row]) begin
      need = (debounce_setting == '0) ? CNT_W'(1) : debounce_setting;
      next_count = {1'b0, keypad_state.count} + 1'b1;
      if (next_count >= {1'b0, need}) begin
        col = keypad_state.phase - 2'd1;
        if (keypad_state.row == 2'd3) begin
          keypad_state.key = (col == 2'd0) ? KEY_STAR : (col == 2'd1) ? 4'd0 : KEY_HASH;
        end else begin
          keypad_state.key = {2'b00, keypad_state.row} * 4'd3 + {2'b00, col} + 4'd1;
        end
        keypad_state.pressed = 1'b1;
        keypad_state.count = '0;
        keypad_state.phase = PHASE_IDLE;
        res.key_event = 1'b1;
      end else begin
        keypad_state.count = next_count[CNT_W-1:0];
      end
    end else begin
      keypad_state.count = '0;
      if (keypad_state.phase == PHASE_COL2) keypad_state.phase = PHASE_IDLE;
      else keypad_state.phase = keypad_state.phase + 2'd1;
    end
    res.column_drive = (keypad_state.phase == PHASE_IDLE) ? '0 :
                       ~(COL_W'(1) << (keypad_state.phase - 2'd1));
    res.key_code = keypad_state.key;
    res.key_pressed = keypad_state.pressed;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
    if (mismatches < MAX_REPORTED) begin
      $display("result %0d: %s got %0d expected %0d", checked_results, what, got, want);
    end
    mismatches++;
  endtask

  task automatic push_tick(logic [ROW_W-1:0] rows, logic clear);
    tick_t t;
    t.rows = rows;
    t.clear = clear;
    pending_ticks.push_back(t);
  endtask

  // start tick on the row, one high tick per skipped column, then the low run
  task automatic queue_keystroke(int row, int col, int need);
    logic [ROW_W-1:0] rows;
    int k;
    rows = 4'($urandom) | ~(4'hf << row);
    rows[row] = 1'b0;
    push_tick(rows, $urandom_range(7) == 0);
    for (k = 0; k < col; k++) begin
      rows = 4'($urandom);
      rows[row] = 1'b1;
      push_tick(rows, $urandom_range(7) == 0);
    end
    for (k = 0; k < need; k++) begin
      rows = 4'($urandom);
      rows[row] = ($urandom_range(40) == 0);
      push_tick(rows, $urandom_range(7) == 0);
    end
  endtask

  task automatic queue_random(int n);
    int target;
    int need;
    int burst;
    int k;
    target = pending_ticks.size() + n;
    need = (debounce_setting == '0) ? 1 : int'(debounce_setting);
    while (pending_ticks.size() < target) begin
      case ($urandom_range(9))
        0, 1: begin
          burst = $urandom_range(1, 4);
          for (k = 0; k < burst; k++) push_tick(4'($urandom), $urandom_range(3) == 0);
          repeat (3) push_tick(4'hf, $urandom_range(7) == 0);
        end
        2: push_tick(4'hf, $urandom_range(3) == 0);
        default: queue_keystroke($urandom_range(3), $urandom_range(2), need);
      endcase
    end
  endtask

  task automatic write_reg(logic addr, logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == REG_DEBOUNCE) debounce_setting = value;
    else scan_enable_setting = value[0];
  endtask

  task automatic wait_for_drain();
    while (pending_ticks.size() != 0 || in_tvalid || predicted_outputs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : tick_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_outputs.push_back(predict_tick(pending_ticks.pop_front()));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {3'b000, pending_ticks[0]};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    kps_result_t seen;
    kps_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[8:0];
      if (predicted_outputs.size() == 0) begin
        report_mismatch("unexpected transaction", seen, '0);
      end else begin
        want = predicted_outputs.pop_front();
        if (seen.column_drive !== want.column_drive)
          report_mismatch("column_drive", 9'(seen.column_drive), 9'(want.column_drive));
        if (seen.key_code !== want.key_code)
          report_mismatch("key_code", 9'(seen.key_code), 9'(want.key_code));
        if (seen.key_pressed !== want.key_pressed)
          report_mismatch("key_pressed", 9'(seen.key_pressed), 9'(want.key_pressed));
        if (seen.key_event !== want.key_event)
          report_mismatch("key_event", 9'(seen.key_event), 9'(want.key_event));
      end
      checked_results++;
    end
    out_tready <= rst_n && rx_hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (holds_started != holds_requested) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      holds_started <= holds_started + 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("matrix_keypad_scan_debounce_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks, sender idles lightly, receiver heavily
    send_idle_pct = 38;
    recv_idle_pct = 81;
    write_reg(REG_DEBOUNCE, 8'd1);
    write_reg(REG_SCAN_ENABLE, 8'd1);
    push_tick(4'hf, 1'b0);
    push_tick(4'h0, 1'b1);
    push_tick(4'h0, 1'b1);
    push_tick(4'b0111, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'b0111, 1'b0);
    push_tick(4'b0111, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'b0111, 1'b0);
    push_tick(4'b0111, 1'b0);
    push_tick(4'b0111, 1'b0);
    push_tick(4'hf, 1'b1);
    push_tick(4'b0111, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'b1101, 1'b0);
    push_tick(4'b1101, 1'b1);
    push_tick(4'b1011, 1'b0);
    push_tick(4'hf, 1'b0);
    push_tick(4'b1011, 1'b0);
    wait_for_drain();

    write_reg(REG_DEBOUNCE, 8'd3);
    queue_random(100);
    wait_for_drain();

    // idling swapped, longest debounce
    send_idle_pct = 81;
    recv_idle_pct = 38;
    write_reg(REG_DEBOUNCE, 8'd255);
    repeat (3) push_tick(4'hf, 1'b0);
    queue_keystroke(3, 2, 255);
    repeat (10) push_tick(4'($urandom), $urandom_range(1) == 1);
    wait_for_drain();

    // zero debounce acts as one; end the phase in the middle of a scan
    write_reg(REG_DEBOUNCE, 8'd0);
    queue_random(150);
    repeat (3) push_tick(4'hf, 1'b0);
    push_tick(4'b1011, 1'b0);
    wait_for_drain();

    // scan disabled: the running scan completes, no new scan starts
    write_reg(REG_SCAN_ENABLE, 8'd0);
    push_tick(4'b1011, 1'b0);
    queue_random(60);
    wait_for_drain();

    // no idling, receiver stalls long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_SCAN_ENABLE, 8'd1);
    write_reg(REG_DEBOUNCE, 8'd5);
    holds_requested <= holds_requested + 1;
    queue_random(150);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("matrix_keypad_scan_debounce_test: clean");
    end else begin
      $display("matrix_keypad_scan_debounce_test: errors");
    end
    $finish;
  end

endmodule

/* matrix_keypad_scan_debounce.f */
rtl/core/kps_pkg.sv
rtl/core/kps_step.sv
rtl/core/matrix_keypad_scan_debounce.sv
test/matrix_keypad_scan_debounce_test.sv
